### rtl/segment_length_statistics_core_assert.svh
// Assertion macros for the segment length statistics core.
`ifndef SEGMENT_LENGTH_STATISTICS_CORE_ASSERT_SVH
`define SEGMENT_LENGTH_STATISTICS_CORE_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define SLS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define SLS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/sls_pkg.sv
// Shared types and constants of the segment length statistics core.
package sls_pkg;

  localparam int COORD_BITS    = 16;
  localparam int LEN_W         = 21;
  localparam int CNT_OUT_W     = 9;
  localparam int MAX_LINES_DEF = 256;
  localparam int FRAC_BITS_DEF = 4;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by;
    logic                         last_in_set;
  } sls_in_t;

  typedef struct packed {
    logic [LEN_W-1:0]     seg_length;
    logic                 stats_valid;
    logic [LEN_W-1:0]     max_length;
    logic [LEN_W-1:0]     min_length;
    logic [LEN_W-1:0]     mean_length;
    logic [CNT_OUT_W-1:0] set_count;
    logic                 set_overflow;
  } sls_out_t;

endpackage

### rtl/segment_length_statistics_core.sv
// Segment length statistics core: bit-serial length, running statistics and mean.
//
// Takes one segment per request and returns one result request holding its length,
// floor(sqrt(dx^2 + dy^2) * 2^FRAC_BITS). The input side stays stalled from acceptance
// until the result is placed in the output register. A bit-serial multiply-accumulate
// forms dx^2 + dy^2, and a restoring square root of COORD_BITS + 1 + FRAC_BITS bits
// then settles one root bit a cycle. A request marked last_in_set also runs a
// restoring division of the running sum by the count, one quotient bit a cycle,
// and then clears the running maximum, minimum, sum, count and overflow flag.
// The result sits in an output register, so the next segment may be accepted and
// worked on while the previous result is still stalled.
module segment_length_statistics_core #(
  parameter int MAX_LINES = sls_pkg::MAX_LINES_DEF,
  parameter int FRAC_BITS = sls_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sls_pkg::sls_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output sls_pkg::sls_out_t out_data
);

  import sls_pkg::*;

  // Widths derived from the configuration.
  localparam int C     = COORD_BITS;
  localparam int ACC_W = 2 * C + 1;                  // dx^2 + dy^2
  localparam int RB    = C + 1 + FRAC_BITS;          // root bits
  localparam int RAD_W = 2 * RB;                     // radicand bits
  localparam int CW    = $clog2(MAX_LINES + 1);      // count bits
  localparam int SW    = LEN_W + $clog2(MAX_LINES);  // sum bits
  localparam int MAXN  = (SW > RB) ? ((SW > C) ? SW : C) : ((RB > C) ? RB : C);
  localparam int STEP_W = $clog2(MAXN);

  localparam logic [CW-1:0]    MAX_CNT  = CW'(MAX_LINES);
  localparam logic [LEN_W-1:0] LEN_ONES = '1;

  // Sequencer codes.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MAC  = 3'd1;
  localparam logic [2:0] ST_SQRT = 3'd2;
  localparam logic [2:0] ST_UPD  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              last_r, last_nxt;
  logic [C-1:0]      adx_r, adx_nxt, ady_r, ady_nxt;
  logic [C-1:0]      sx_r, sx_nxt, sy_r, sy_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [RAD_W-1:0]  rad_r, rad_nxt;
  logic [RB+1:0]     srem_r, srem_nxt;
  logic [RB-1:0]     root_r, root_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [SW-1:0]     dsh_r, dsh_nxt;
  logic [CW-1:0]     drem_r, drem_nxt;
  logic [LEN_W-1:0]  max_r, max_nxt, min_r, min_nxt;
  logic [SW-1:0]     sum_r, sum_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              ovf_r, ovf_nxt;
  logic              out_valid_r, out_valid_nxt;
  sls_out_t          out_data_r, out_data_nxt;

  // Absolute coordinate differences, taken at acceptance.
  logic [C:0]   dx, dy, ndx, ndy;
  logic [C-1:0] adx_c, ady_c;

  assign dx    = {in_data.bx[C-1], in_data.bx} - {in_data.ax[C-1], in_data.ax};
  assign dy    = {in_data.by[C-1], in_data.by} - {in_data.ay[C-1], in_data.ay};
  assign ndx   = -dx;
  assign ndy   = -dy;
  assign adx_c = dx[C] ? ndx[C-1:0] : dx[C-1:0];
  assign ady_c = dy[C] ? ndy[C-1:0] : dy[C-1:0];

  // Multiply-accumulate step, MSB of the multiplier first:
  // acc = 2*acc + bit_x*adx + bit_y*ady, which ends at adx^2 + ady^2.
  logic [ACC_W-1:0] mac_px, mac_py, mac_sum;

  assign mac_px  = sx_r[C-1] ? ACC_W'(adx_r) : '0;
  assign mac_py  = sy_r[C-1] ? ACC_W'(ady_r) : '0;
  assign mac_sum = {acc_r[ACC_W-2:0], 1'b0} + mac_px + mac_py;

  // Restoring square root step: bring down two radicand bits, try root*4+1.
  logic [RB+1:0] sq_rem, sq_trial;
  logic          sq_ge;

  assign sq_rem   = {srem_r[RB-1:0], rad_r[RAD_W-1 -: 2]};
  assign sq_trial = {root_r, 2'b01};
  assign sq_ge    = sq_rem >= sq_trial;

  // Running statistics after folding in the current length.
  logic             cnt_room;
  logic [LEN_W-1:0] max_upd, min_upd;
  logic [SW-1:0]    sum_upd;
  logic [CW-1:0]    cnt_upd;

  assign cnt_room = cnt_r < MAX_CNT;
  assign max_upd  = (cnt_room && len_r > max_r) ? len_r : max_r;
  assign min_upd  = (cnt_room && len_r < min_r) ? len_r : min_r;
  assign sum_upd  = cnt_room ? sum_r + SW'(len_r) : sum_r;
  assign cnt_upd  = cnt_room ? cnt_r + CW'(1) : cnt_r;

  // Restoring division step: one quotient bit into the bottom of the shifter.
  logic [CW:0] dv_trial;
  logic [CW:0] dv_diff;
  logic        dv_ge;

  assign dv_trial = {drem_r, dsh_r[SW-1]};
  assign dv_ge    = dv_trial >= {1'b0, cnt_r};
  assign dv_diff  = dv_trial - {1'b0, cnt_r};

  logic out_acc;
  assign out_acc = out_valid_r && !out_stall;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    last_nxt      = last_r;
    adx_nxt       = adx_r;
    ady_nxt       = ady_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    acc_nxt       = acc_r;
    rad_nxt       = rad_r;
    srem_nxt      = srem_r;
    root_nxt      = root_r;
    len_nxt       = len_r;
    dsh_nxt       = dsh_r;
    drem_nxt      = drem_r;
    max_nxt       = max_r;
    min_nxt       = min_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    // Drop the result once the far side takes it.
    if (out_acc) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          adx_nxt   = adx_c;
          ady_nxt   = ady_c;
          sx_nxt    = adx_c;
          sy_nxt    = ady_c;
          acc_nxt   = '0;
          last_nxt  = in_data.last_in_set;
          step_nxt  = STEP_W'(C - 1);
          state_nxt = ST_MAC;
        end
      end
      ST_MAC: begin
        acc_nxt = mac_sum;
        sx_nxt  = {sx_r[C-2:0], 1'b0};
        sy_nxt  = {sy_r[C-2:0], 1'b0};
        if (step_r == '0) begin
          // Scale by 4^FRAC_BITS so the root carries the fraction bits.
          rad_nxt   = RAD_W'(mac_sum) << (2 * FRAC_BITS);
          srem_nxt  = '0;
          root_nxt  = '0;
          step_nxt  = STEP_W'(RB - 1);
          state_nxt = ST_SQRT;
        end else begin
          step_nxt = step_r - STEP_W'(1);
        end
      end
      ST_SQRT: begin
        rad_nxt  = {rad_r[RAD_W-3:0], 2'b00};
        srem_nxt = sq_ge ? sq_rem - sq_trial : sq_rem;
        root_nxt = {root_r[RB-2:0], sq_ge};
        if (step_r == '0) begin
          len_nxt   = LEN_W'({root_r[RB-2:0], sq_ge});
          state_nxt = ST_UPD;
        end else begin
          step_nxt = step_r - STEP_W'(1);
        end
      end
      ST_UPD: begin
        max_nxt = max_upd;
        min_nxt = min_upd;
        sum_nxt = sum_upd;
        cnt_nxt = cnt_upd;
        if (!cnt_room) begin
          ovf_nxt = 1'b1;
        end
        dsh_nxt  = sum_upd;
        drem_nxt = '0;
        step_nxt = STEP_W'(SW - 1);
        state_nxt = last_r ? ST_DIV : ST_FIN;
      end
      ST_DIV: begin
        dsh_nxt  = {dsh_r[SW-2:0], dv_ge};
        drem_nxt = dv_ge ? dv_diff[CW-1:0] : dv_trial[CW-1:0];
        if (step_r == '0) begin
          state_nxt = ST_FIN;
        end else begin
          step_nxt = step_r - STEP_W'(1);
        end
      end
      ST_FIN: begin
        // Hold until the output register is free.
        if (!out_valid_r || out_acc) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt            = '0;
          out_data_nxt.seg_length = len_r;
          if (last_r) begin
            out_data_nxt.stats_valid  = 1'b1;
            out_data_nxt.max_length   = max_r;
            out_data_nxt.min_length   = min_r;
            out_data_nxt.mean_length  = (cnt_r == '0) ? '0 : LEN_W'(dsh_r);
            out_data_nxt.set_count    = CNT_OUT_W'(cnt_r);
            out_data_nxt.set_overflow = ovf_r;
            max_nxt = '0;
            min_nxt = LEN_ONES;
            sum_nxt = '0;
            cnt_nxt = '0;
            ovf_nxt = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and running statistics.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      max_r       <= '0;
      min_r       <= LEN_ONES;
      sum_r       <= '0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      max_r       <= max_nxt;
      min_r       <= min_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

  // Datapath shifters and the output register.
  always_ff @(posedge clk) begin
    step_r     <= step_nxt;
    last_r     <= last_nxt;
    adx_r      <= adx_nxt;
    ady_r      <= ady_nxt;
    sx_r       <= sx_nxt;
    sy_r       <= sy_nxt;
    acc_r      <= acc_nxt;
    rad_r      <= rad_nxt;
    srem_r     <= srem_nxt;
    root_r     <= root_nxt;
    len_r      <= len_nxt;
    dsh_r      <= dsh_nxt;
    drem_r     <= drem_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`include "segment_length_statistics_core_assert.svh"

  // An accepted segment keeps the input side stalled while it is worked on.
  `SLS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "input not held off after acceptance")
  // The count never passes the set limit.
  `SLS_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, cnt_r <= MAX_CNT, "running count beyond limit")
  // A closing result has its mean no larger than its maximum.
  `SLS_ASSERT_NOW(a_mean_le_max, clk, rst_n, out_valid && out_data.stats_valid, out_data.mean_length <= out_data.max_length, "mean above maximum")
  // Results that do not close a set carry no statistics.
  `SLS_ASSERT_NOW(a_no_stats_open, clk, rst_n, out_valid && !out_data.stats_valid, out_data.max_length == '0 && out_data.set_count == '0 && !out_data.set_overflow, "statistics on an open set")

endmodule
